// ----- hdl/dllc_pkg.sv -----
// ----------------------------------------------------------------------------
// dllc_pkg
// shared op codes, field widths and defaults of the linked list cursor block
// ----------------------------------------------------------------------------
`default_nettype none

package dllc_pkg;

	localparam int OP_W             = 5;
	localparam int WORD_W           = 32;
	localparam int DEF_POOL_NODES   = 16;
	localparam int DEF_DATA_BITS    = 32;

	localparam logic [OP_W-1:0] OP_INS_FIRST  = 5'd0;
	localparam logic [OP_W-1:0] OP_INS_LAST   = 5'd1;
	localparam logic [OP_W-1:0] OP_CUR_FIRST  = 5'd2;
	localparam logic [OP_W-1:0] OP_CUR_LAST   = 5'd3;
	localparam logic [OP_W-1:0] OP_RD_FIRST   = 5'd4;
	localparam logic [OP_W-1:0] OP_RD_LAST    = 5'd5;
	localparam logic [OP_W-1:0] OP_DEL_FIRST  = 5'd6;
	localparam logic [OP_W-1:0] OP_DEL_LAST   = 5'd7;
	localparam logic [OP_W-1:0] OP_DEL_AFTER  = 5'd8;
	localparam logic [OP_W-1:0] OP_DEL_BEFORE = 5'd9;
	localparam logic [OP_W-1:0] OP_INS_AFTER  = 5'd10;
	localparam logic [OP_W-1:0] OP_INS_BEFORE = 5'd11;
	localparam logic [OP_W-1:0] OP_RD_CUR     = 5'd12;
	localparam logic [OP_W-1:0] OP_WRITE_CUR  = 5'd13;
	localparam logic [OP_W-1:0] OP_NEXT       = 5'd14;
	localparam logic [OP_W-1:0] OP_PREV       = 5'd15;
	localparam logic [OP_W-1:0] OP_CLEAR      = 5'd16;

	typedef struct packed {
		logic err;
		logic rd_hit;
		logic cur_act;
	} dllc_flags_t;

endpackage

`default_nettype wire

// ----- hdl/dllc_value_mem.sv -----
// ----------------------------------------------------------------------------
// dllc_value_mem
// node data memory: one write port, one registered read port, with
// conversion between the word format and the stored width
// ----------------------------------------------------------------------------
`default_nettype none

module dllc_value_mem
	import dllc_pkg::*;
#(
	parameter int POOL_NODES = DEF_POOL_NODES,
	parameter int DATA_BITS  = DEF_DATA_BITS,
	localparam int AW        = $clog2(POOL_NODES)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [WORD_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [WORD_W-1:0] rword
);

	logic [DATA_BITS-1:0] mem_q [POOL_NODES];
	logic [DATA_BITS-1:0] rdata_q;
	logic [DATA_BITS-1:0] wdata_st;

	generate
		if (DATA_BITS <= WORD_W) begin : g_narrow_st
			assign wdata_st = wdata[DATA_BITS-1:0];
		end else begin : g_wide_st
			assign wdata_st = {{(DATA_BITS-WORD_W){wdata[WORD_W-1]}}, wdata};
		end
		if (DATA_BITS < WORD_W) begin : g_narrow_rd
			assign rword = {{(WORD_W-DATA_BITS){rdata_q[DATA_BITS-1]}}, rdata_q};
		end else begin : g_wide_rd
			assign rword = rdata_q[WORD_W-1:0];
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata_st;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/dllc_links.sv -----
// ----------------------------------------------------------------------------
// dllc_links
// list structure: next and prev links, free map, first, last and cursor
// pointers, op decode and the registered update of all of them
// ----------------------------------------------------------------------------
`default_nettype none

module dllc_links
	import dllc_pkg::*;
#(
	parameter int POOL_NODES = DEF_POOL_NODES,
	localparam int AW        = $clog2(POOL_NODES),
	localparam int IW        = $clog2(POOL_NODES + 1)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire logic [OP_W-1:0] op,
	output logic                 mem_we,
	output logic      [AW-1:0]   mem_waddr,
	output logic                 mem_re,
	output logic      [AW-1:0]   mem_raddr,
	output dllc_flags_t          flags
);

	localparam logic [IW-1:0] NIL = IW'(POOL_NODES);

	logic [IW-1:0]         head_q, tail_q, cur_q;
	logic [POOL_NODES-1:0] free_q;
	logic [IW-1:0]         nxt_q [POOL_NODES];
	logic [IW-1:0]         prv_q [POOL_NODES];

	logic          is_ins, is_ins_cur, is_del, is_rd, is_wr_cur, is_clear;
	logic          cur_ok, fr_ok, un_ok, rd_ok;
	logic [IW-1:0] cur_nxt, cur_prv, fr_idx;
	logic [IW-1:0] un_n, un_a, un_b, lk_a, lk_b, rd_n;
	logic [IW-1:0] ch_a, ch_b, a_val, b_val, cur_nx;
	logic          do_link, do_unlink, ins_err;

	assign cur_ok  = cur_q < NIL;
	assign cur_nxt = cur_ok ? nxt_q[cur_q[AW-1:0]] : NIL;
	assign cur_prv = cur_ok ? prv_q[cur_q[AW-1:0]] : NIL;

	always_comb begin
		is_ins     = 1'b0;
		is_ins_cur = 1'b0;
		is_del     = 1'b0;
		is_rd      = 1'b0;
		is_wr_cur  = 1'b0;
		is_clear   = 1'b0;
		un_n       = NIL;
		lk_a       = NIL;
		lk_b       = NIL;
		rd_n       = NIL;
		cur_nx     = cur_q;
		unique case (op) inside
			OP_INS_FIRST: begin
				is_ins = 1'b1;
				lk_b   = head_q;
			end
			OP_INS_LAST: begin
				is_ins = 1'b1;
				lk_a   = tail_q;
			end
			OP_INS_AFTER: begin
				is_ins     = 1'b1;
				is_ins_cur = 1'b1;
				lk_a       = cur_q;
				lk_b       = cur_nxt;
			end
			OP_INS_BEFORE: begin
				is_ins     = 1'b1;
				is_ins_cur = 1'b1;
				lk_a       = cur_prv;
				lk_b       = cur_q;
			end
			OP_CUR_FIRST: cur_nx = head_q;
			OP_CUR_LAST:  cur_nx = tail_q;
			OP_RD_FIRST: begin
				is_rd = 1'b1;
				rd_n  = head_q;
			end
			OP_RD_LAST: begin
				is_rd = 1'b1;
				rd_n  = tail_q;
			end
			OP_RD_CUR: begin
				is_rd = 1'b1;
				rd_n  = cur_q;
			end
			OP_DEL_FIRST: begin
				is_del = 1'b1;
				un_n   = head_q;
			end
			OP_DEL_LAST: begin
				is_del = 1'b1;
				un_n   = tail_q;
			end
			OP_DEL_AFTER: begin
				is_del = 1'b1;
				un_n   = cur_nxt;
			end
			OP_DEL_BEFORE: begin
				is_del = 1'b1;
				un_n   = cur_prv;
			end
			OP_WRITE_CUR: is_wr_cur = 1'b1;
			OP_NEXT:      cur_nx = cur_nxt;
			OP_PREV:      cur_nx = cur_prv;
			OP_CLEAR: begin
				is_clear = 1'b1;
				cur_nx   = NIL;
			end
			default: ;
		endcase
		if (is_del && (un_n < NIL) && (cur_q == un_n)) begin
			cur_nx = NIL;
		end
	end

	// lowest free node
	always_comb begin
		fr_idx = NIL;
		for (int i = POOL_NODES - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				fr_idx = IW'(i);
			end
		end
	end

	assign fr_ok = fr_idx < NIL;
	assign un_ok = un_n < NIL;
	assign rd_ok = rd_n < NIL;
	assign un_a  = un_ok ? prv_q[un_n[AW-1:0]] : NIL;
	assign un_b  = un_ok ? nxt_q[un_n[AW-1:0]] : NIL;

	assign do_link   = fire && is_ins && (!is_ins_cur || cur_ok) && fr_ok;
	assign ins_err   = is_ins && (!is_ins_cur || cur_ok) && !fr_ok;
	assign do_unlink = fire && is_del && un_ok;

	// neighbors that change and what they now point to
	assign ch_a  = do_link ? lk_a : un_a;
	assign ch_b  = do_link ? lk_b : un_b;
	assign a_val = do_link ? fr_idx : un_b;
	assign b_val = do_link ? fr_idx : un_a;

	assign mem_we    = (do_link || (fire && is_wr_cur && cur_ok));
	assign mem_waddr = do_link ? fr_idx[AW-1:0] : cur_q[AW-1:0];
	assign mem_re    = fire && is_rd && rd_ok;
	assign mem_raddr = rd_n[AW-1:0];

	assign flags.err     = (is_rd && !rd_ok) || ins_err;
	assign flags.rd_hit  = is_rd && rd_ok;
	assign flags.cur_act = cur_nx < NIL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NIL;
			tail_q <= NIL;
			cur_q  <= NIL;
			free_q <= '1;
		end else if (fire) begin
			cur_q <= cur_nx;
			if (is_clear) begin
				head_q <= NIL;
				tail_q <= NIL;
				free_q <= '1;
			end else if (do_link || do_unlink) begin
				if (ch_a >= NIL) begin
					head_q <= a_val;
				end
				if (ch_b >= NIL) begin
					tail_q <= b_val;
				end
				if (do_link) begin
					free_q[fr_idx[AW-1:0]] <= 1'b0;
				end else begin
					free_q[un_n[AW-1:0]] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < POOL_NODES; i++) begin
			if (do_link && (fr_idx == IW'(i))) begin
				nxt_q[i] <= lk_b;
				prv_q[i] <= lk_a;
			end
			if ((do_link || do_unlink) && (ch_a == IW'(i))) begin
				nxt_q[i] <= a_val;
			end
			if ((do_link || do_unlink) && (ch_b == IW'(i))) begin
				prv_q[i] <= b_val;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/doubly_linked_list_cursor.sv -----
// ----------------------------------------------------------------------------
// doubly_linked_list_cursor
// bounded doubly linked list of data words with first, last and cursor
// pointers; one op per word in, one result word out
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | op, value
//  out     | out_valid / out_ready| read_value, error, cursor_active
//
//  one op per cycle while out_ready is high; its result is presented the cycle after acceptance
//  the whole op is done in one pass through the link logic and one node
//  memory access, the read data landing in the result register
//  reset empties the list and frees every node; no clearing pass
//  a stalled result holds and in_ready drops until it is taken
// ----------------------------------------------------------------------------
`default_nettype none

module doubly_linked_list_cursor
	import dllc_pkg::*;
#(
	parameter int POOL_NODES = DEF_POOL_NODES,
	parameter int DATA_BITS  = DEF_DATA_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic        [OP_W-1:0]   op,
	input  wire logic signed [WORD_W-1:0] value,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed      [WORD_W-1:0] read_value,
	output logic                          error,
	output logic                          cursor_active
);

	localparam int AW = $clog2(POOL_NODES);

	logic              fire;
	logic              out_valid_q;
	dllc_flags_t       flags, flags_q;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [WORD_W-1:0] rword;

	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	dllc_links #(
		.POOL_NODES(POOL_NODES)
	) u_links (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.op       (op),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.flags    (flags)
	);

	dllc_value_mem #(
		.POOL_NODES(POOL_NODES),
		.DATA_BITS (DATA_BITS)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(value),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rword(rword)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			flags_q <= flags;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_value    = flags_q.rd_hit ? rword : '0;
	assign error         = flags_q.err;
	assign cursor_active = flags_q.cur_act;

endmodule

`default_nettype wire
